FILE: hdl/ciffv_pkg.sv
// Shared types and constants for the CIFF header validator.
`timescale 1ns / 1ps

package ciffv_pkg;

    // status codes of a finished header
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_MAGIC = 3'd1;
    localparam logic [2:0] ST_SIZE  = 3'd2;
    localparam logic [2:0] ST_TRUNC = 3'd3;
    localparam logic [2:0] ST_NLTAG = 3'd4;

    // byte framing
    localparam logic [4:0] MAGIC_LAST = 5'd3;
    localparam logic [4:0] SIZE_END   = 5'd12;
    localparam logic [4:0] WIDTH_END  = 5'd20;
    localparam logic [4:0] FIXED_LAST = 5'd27;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] MAGIC [4]  = '{8'h43, 8'h49, 8'h46, 8'h46};

    // front-to-back queue
    localparam int QDEPTH = 2;

    // one finished header, as the front hands it to the back
    typedef struct packed {
        logic        magic_err;  // magic mismatch seen at the fourth byte
        logic        checked;    // all fixed bytes came, size check owed
        logic        nltag;      // newline seen inside a tag
        logic        trunc;      // ended before the tag section or inside a tag
        logic [63:0] data_size;
        logic [63:0] image_width;
        logic [63:0] image_height;
        logic [15:0] caption_length;
        logic [15:0] tag_count;
    } t_job;

endpackage

FILE: hdl/ciffv_front.sv
// Byte parser: walks the header bytes and emits one job per header.
`timescale 1ns / 1ps

module ciffv_front #(
    parameter int CNT_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_full,
    output logic              o_push,
    output ciffv_pkg::t_job   o_job
);

    typedef enum logic [1:0] {
        PH_FIXED,
        PH_CAPTION,
        PH_TAGS
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [4:0]         r_pos, n_pos;
    logic [63:0]        r_size, n_size;
    logic [63:0]        r_width, n_width;
    logic [63:0]        r_height, n_height;
    logic               r_magic_ok, n_magic_ok;
    logic               r_magic_err, n_magic_err;
    logic               r_nltag, n_nltag;
    logic               r_tag_open, n_tag_open;
    logic [CNT_W-1:0]   r_caption, n_caption;
    logic [CNT_W-1:0]   r_tags, n_tags;
    logic [2:0]         w_lane;
    logic               w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && i_last_byte;
    // byte lane within an 8-byte field: (pos - 4) mod 8
    assign w_lane   = {~r_pos[2], r_pos[1:0]};

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_size      = r_size;
        n_width     = r_width;
        n_height    = r_height;
        n_magic_ok  = r_magic_ok;
        n_magic_err = r_magic_err;
        n_nltag     = r_nltag;
        n_tag_open  = r_tag_open;
        n_caption   = r_caption;
        n_tags      = r_tags;
        case (r_phase)
            PH_FIXED: begin
                if (r_pos <= ciffv_pkg::MAGIC_LAST) begin
                    if (i_data_byte != ciffv_pkg::MAGIC[r_pos[1:0]]) begin
                        n_magic_ok = 1'b0;
                    end
                    if (r_pos == ciffv_pkg::MAGIC_LAST && !n_magic_ok) begin
                        n_magic_err = 1'b1;
                    end
                end else if (r_pos < ciffv_pkg::SIZE_END) begin
                    n_size[{w_lane, 3'b000} +: 8] = i_data_byte;
                end else if (r_pos < ciffv_pkg::WIDTH_END) begin
                    n_width[{w_lane, 3'b000} +: 8] = i_data_byte;
                end else begin
                    n_height[{w_lane, 3'b000} +: 8] = i_data_byte;
                end
                if (r_pos >= ciffv_pkg::FIXED_LAST) begin
                    n_phase = PH_CAPTION;
                    n_pos   = '0;
                end else begin
                    n_pos = r_pos + 5'd1;
                end
            end
            PH_CAPTION: begin
                if (i_data_byte == ciffv_pkg::CH_NL) begin
                    n_phase = PH_TAGS;
                end else if (r_caption != '1) begin
                    n_caption = r_caption + 1'b1;
                end
            end
            PH_TAGS: begin
                if (i_data_byte == ciffv_pkg::CH_NUL) begin
                    n_tag_open = 1'b0;
                    if (r_tags != '1) begin
                        n_tags = r_tags + 1'b1;
                    end
                end else begin
                    n_tag_open = 1'b1;
                    if (i_data_byte == ciffv_pkg::CH_NL) begin
                        n_nltag = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_FIXED;
            end
        endcase
    end

    always_comb begin
        o_job.magic_err      = n_magic_err;
        o_job.checked        = (n_phase != PH_FIXED);
        o_job.nltag          = n_nltag;
        o_job.trunc          = (n_phase != PH_TAGS) || n_tag_open;
        o_job.data_size      = n_size;
        o_job.image_width    = n_width;
        o_job.image_height   = n_height;
        o_job.caption_length = 16'(n_caption);
        o_job.tag_count      = 16'(n_tags);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_phase     <= PH_FIXED;
            r_pos       <= '0;
            r_size      <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_magic_ok  <= 1'b1;
            r_magic_err <= 1'b0;
            r_nltag     <= 1'b0;
            r_tag_open  <= 1'b0;
            r_caption   <= '0;
            r_tags      <= '0;
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_size      <= n_size;
            r_width     <= n_width;
            r_height    <= n_height;
            r_magic_ok  <= n_magic_ok;
            r_magic_err <= n_magic_err;
            r_nltag     <= n_nltag;
            r_tag_open  <= n_tag_open;
            r_caption   <= n_caption;
            r_tags      <= n_tags;
        end
    end

`ifndef ASSERT_OFF
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_pos == '0 && r_phase == PH_FIXED && r_magic_ok))
        else $error("front did not restart after the final byte");
`endif

endmodule

FILE: hdl/ciffv_fifo.sv
// Short job queue between parser and checker.
`timescale 1ns / 1ps

module ciffv_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ciffv_pkg::t_job   i_job,
    output logic              o_full,
    input  logic              i_pop,
    output ciffv_pkg::t_job   o_job,
    output logic              o_avail
);

    localparam int PTR_W = (ciffv_pkg::QDEPTH > 1) ? $clog2(ciffv_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(ciffv_pkg::QDEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(ciffv_pkg::QDEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(ciffv_pkg::QDEPTH - 1);

    ciffv_pkg::t_job   r_mem [ciffv_pkg::QDEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == DEPTH_C);
    assign o_avail = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_C) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_C) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_avail))
        else $error("job popped from an empty queue");
`endif

endmodule

FILE: hdl/ciffv_back.sv
// Size checker and result register: runs width*height*3 on a shared multiplier.
`timescale 1ns / 1ps

module ciffv_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ciffv_pkg::t_job      i_job,
    input  logic                 i_avail,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_status,
    output logic signed [63:0]   o_content_size,
    output logic signed [63:0]   o_image_width,
    output logic signed [63:0]   o_image_height,
    output logic [15:0]          o_caption_length,
    output logic [15:0]          o_tag_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_CMP
    } t_state;

    t_state            r_state;
    ciffv_pkg::t_job   r_job;
    ciffv_pkg::t_job   r_out;
    logic [2:0]        r_status;
    logic              r_valid;
    logic [63:0]       r_p0;
    logic [31:0]       r_p1;
    logic [31:0]       r_p2;
    logic [63:0]       r_prod;
    logic [31:0]       w_a;
    logic [31:0]       w_b;
    logic [63:0]       w_mul;
    logic              w_free;
    logic              w_emit;
    logic              w_mismatch;
    ciffv_pkg::t_job   w_src;

    function automatic logic [2:0] f_status(input ciffv_pkg::t_job j, input logic mis);
        logic [2:0] s;
        if (j.magic_err) begin
            s = ciffv_pkg::ST_MAGIC;
        end else if (j.checked && mis) begin
            s = ciffv_pkg::ST_SIZE;
        end else if (j.nltag) begin
            s = ciffv_pkg::ST_NLTAG;
        end else if (j.trunc) begin
            s = ciffv_pkg::ST_TRUNC;
        end else begin
            s = ciffv_pkg::ST_OK;
        end
        return s;
    endfunction

    // one 32x32 multiplier, operands picked by step
    always_comb begin
        case (r_state)
            S_MUL1: begin
                w_a = r_job.image_width[31:0];
                w_b = r_job.image_height[63:32];
            end
            S_MUL2: begin
                w_a = r_job.image_width[63:32];
                w_b = r_job.image_height[31:0];
            end
            default: begin
                w_a = r_job.image_width[31:0];
                w_b = r_job.image_height[31:0];
            end
        endcase
    end
    assign w_mul = 64'(w_a) * 64'(w_b);

    assign w_mismatch = (r_job.data_size != (r_prod + {r_prod[62:0], 1'b0}));
    assign w_free     = !r_valid || i_ready;
    assign o_pop      = (r_state == S_IDLE) && i_avail && (i_job.checked || w_free);
    assign w_emit     = (o_pop && !i_job.checked) || (r_state == S_CMP && w_free);
    assign w_src      = (r_state == S_CMP) ? r_job : i_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_emit || (r_valid && !i_ready);
            if (w_emit) begin
                r_out    <= w_src;
                r_status <= f_status(w_src, (r_state == S_CMP) && w_mismatch);
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_job.checked) begin
                        r_job   <= i_job;
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_p0    <= w_mul;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p1    <= w_mul[31:0];
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2    <= w_mul[31:0];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_prod  <= r_p0 + {r_p1 + r_p2, 32'b0};
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_content_size   = r_out.data_size;
    assign o_image_width    = r_out.image_width;
    assign o_image_height   = r_out.image_height;
    assign o_caption_length = r_out.caption_length;
    assign o_tag_count      = r_out.tag_count;

`ifndef ASSERT_OFF
    a_busy_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> r_job.checked)
        else $error("checker busy on a job that needs no size check");
    a_start_popped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL0) |-> $past(o_pop))
        else $error("size check started without a queue pop");
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_valid)
        else $error("result written but not presented");
`endif

endmodule

FILE: hdl/ciff_header_validator.sv
// Top level of the CIFF header validator: parser, job queue, size checker.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+------------------------------------------
//  in      | in  | i_in_valid / o_in_ready    | i_data_byte[7:0], i_last_byte
//  out     | out | o_out_valid / i_out_ready  | o_status[2:0], o_content_size[63:0],
//          |     |                            | o_image_width, o_image_height,
//          |     |                            | o_caption_length[15:0], o_tag_count[15:0]
//
//  One byte transfer per cycle while o_in_ready is high; each byte is a registered state
//  update in the parser. A header that reaches its caption takes the checker through its
//  one shared 32x32 multiplier (3 partial products, sum, times-3 compare); shorter headers
//  skip it and go from the job queue straight to the result register.
//  Reset (i_rst_n low, synchronous) empties the queue and the result register; no
//  clearing pass is needed.
//  o_in_ready drops only while the 2-entry job queue is full.
`timescale 1ns / 1ps

module ciff_header_validator #(
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_status,
    output logic signed [63:0]   o_content_size,
    output logic signed [63:0]   o_image_width,
    output logic signed [63:0]   o_image_height,
    output logic [15:0]          o_caption_length,
    output logic [15:0]          o_tag_count
);

    // counters saturate at min(2^COUNT_BITS-1, 65535): all-ones of this width
    localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;

    ciffv_pkg::t_job  w_push_job;
    ciffv_pkg::t_job  w_head_job;
    logic             w_push;
    logic             w_full;
    logic             w_pop;
    logic             w_avail;

    // parser: consumes bytes, pushes one job per header on the final byte
    ciffv_front #(
        .CNT_W (CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // decouples the byte stream from the stepped size check
    ciffv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_avail (w_avail)
    );

    // checker: resolves size check and error priority, holds the result
    ciffv_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (w_head_job),
        .i_avail          (w_avail),
        .o_pop            (w_pop),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_status         (o_status),
        .o_content_size   (o_content_size),
        .o_image_width    (o_image_width),
        .o_image_height   (o_image_height),
        .o_caption_length (o_caption_length),
        .o_tag_count      (o_tag_count)
    );

endmodule
